FILE: hdl/polygon_plane_clipper_macros.svh
// ----------------------------------------------------------------------------
// Polygon plane clipper assertion macros
// Concurrent assertion shorthands; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef POLYGON_PLANE_CLIPPER_MACROS_SVH
`define POLYGON_PLANE_CLIPPER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define PCLIP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pclip: same-cycle check failed");
// next-cycle implication
`define PCLIP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pclip: next-cycle check failed");
`else
`define PCLIP_ASSERT_IMP(lbl, ante, cons)
`define PCLIP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/pclip_pkg.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper package
// Shared types, register indexes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package pclip_pkg;

  localparam int NATTR      = 10;
  localparam int ATTR_IDX_W = 4;
  localparam int CNT_W      = 5;   // covers attribute walk and divider steps
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NRM_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NRM_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NRM_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PNT_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PNT_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PNT_Z   = 3'd6;

  localparam int PNT_X_RST = 6553;

  typedef enum logic [4:0] {
    S_IDLE, S_IN_MUL, S_IN_ACC, S_CLASSIFY, S_ROUTE, S_AFTER, S_EDGE,
    S_NUM_MUL, S_NUM_ACC, S_NUM_SAVE, S_DEN_MUL, S_DEN_ACC, S_CHECK,
    S_DIV_START, S_DIV_STEP, S_DIV_DONE, S_INT_MUL, S_INT_ACC,
    S_EDGE_END, S_EMIT, S_FINISH
  } state_t;

  typedef enum logic [1:0] {MUL_IN, MUL_NUM, MUL_DEN, MUL_INT} mul_mode_t;

  typedef enum logic [1:0] {SRC_CUR, SRC_FIRST, SRC_CROSS} src_t;

  typedef struct packed {
    logic                  in_ready;
    logic                  cap_in;
    logic                  acc_clr;
    logic                  mul_go;
    logic                  acc_add;
    mul_mode_t             mode;
    logic [ATTR_IDX_W-1:0] idx;
    logic                  edge_sel;   // 0: prev->cur, 1: cur->first
    logic                  set_cur_in;
    logic                  set_first;
    logic                  upd_prev;
    logic                  latch_num;
    logic                  div_start;
    logic                  div_step;
    logic                  cross_wr;
    logic                  emit;
    src_t                  src;
    logic                  finish;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic mid;
    logic clip_en;
    logic last;
    logic edge_diff;
    logic e_in;
    logic cross_ok;
    logic q_zero;
    logic pend_v;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: hdl/pclip_in_if.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper vertex input channel
// Valid/ready channel carrying one input vertex.
// ----------------------------------------------------------------------------
interface pclip_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] x_coord;
  logic signed [WORD_BITS-1:0] y_coord;
  logic signed [WORD_BITS-1:0] z_coord;
  logic signed [WORD_BITS-1:0] w_coord;
  logic signed [WORD_BITS-1:0] red;
  logic signed [WORD_BITS-1:0] green;
  logic signed [WORD_BITS-1:0] blue;
  logic signed [WORD_BITS-1:0] alpha;
  logic signed [WORD_BITS-1:0] tex_u;
  logic signed [WORD_BITS-1:0] tex_v;
  logic                        last_vertex;

  modport source (output valid, x_coord, y_coord, z_coord, w_coord, red, green,
                  blue, alpha, tex_u, tex_v, last_vertex, input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, w_coord, red, green,
                blue, alpha, tex_u, tex_v, last_vertex, output ready);
endinterface

FILE: hdl/pclip_out_if.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper vertex output channel
// Valid/ready channel carrying one clipped result.
// ----------------------------------------------------------------------------
interface pclip_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] x_out;
  logic signed [WORD_BITS-1:0] y_out;
  logic signed [WORD_BITS-1:0] z_out;
  logic signed [WORD_BITS-1:0] w_out;
  logic signed [WORD_BITS-1:0] red_out;
  logic signed [WORD_BITS-1:0] green_out;
  logic signed [WORD_BITS-1:0] blue_out;
  logic signed [WORD_BITS-1:0] alpha_out;
  logic signed [WORD_BITS-1:0] tex_u_out;
  logic signed [WORD_BITS-1:0] tex_v_out;
  logic                        last_out;
  logic                        empty_polygon;

  modport source (output valid, x_out, y_out, z_out, w_out, red_out, green_out,
                  blue_out, alpha_out, tex_u_out, tex_v_out, last_out,
                  empty_polygon, input ready);
  modport sink (input valid, x_out, y_out, z_out, w_out, red_out, green_out,
                blue_out, alpha_out, tex_u_out, tex_v_out, last_out,
                empty_polygon, output ready);
endinterface

FILE: hdl/pclip_cfg_if.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper configuration channel
// Valid/ready register write channel: index and data.
// ----------------------------------------------------------------------------
interface pclip_cfg_if #(parameter int WORD_BITS = 32);
  logic                            valid;
  logic                            ready;
  logic [pclip_pkg::CFG_IDX_W-1:0] index;
  logic [WORD_BITS-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/pclip_ctrl.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper controller
// Sequences classify, edge crossing, divide, interpolate and emit steps.
// ----------------------------------------------------------------------------
module pclip_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pclip_pkg::dp_stat_t stat,
  output pclip_pkg::dp_cmd_t  cmd
);

  pclip_pkg::state_t            state_r, state_nxt;
  pclip_pkg::state_t            ret_r, ret_nxt;
  pclip_pkg::src_t              src_r, src_nxt;
  logic                         edge_r, edge_nxt;
  logic [pclip_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  localparam logic [pclip_pkg::CNT_W-1:0] DOT_LAST  = pclip_pkg::CNT_W'(2);
  localparam logic [pclip_pkg::CNT_W-1:0] ATTR_LAST = pclip_pkg::CNT_W'(pclip_pkg::NATTR - 1);
  localparam logic [pclip_pkg::CNT_W-1:0] DIV_LAST  = pclip_pkg::CNT_W'(FRAC_BITS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pclip_pkg::S_IDLE;
      ret_r   <= pclip_pkg::S_IDLE;
      src_r   <= pclip_pkg::SRC_CUR;
      edge_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      src_r   <= src_nxt;
      edge_r  <= edge_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    src_nxt   = src_r;
    edge_nxt  = edge_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      pclip_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (stat.in_valid) state_nxt = pclip_pkg::S_IN_MUL;
      end
      pclip_pkg::S_IN_MUL: state_nxt = pclip_pkg::S_IN_ACC;
      pclip_pkg::S_IN_ACC: begin
        if (cnt_r == DOT_LAST) state_nxt = pclip_pkg::S_CLASSIFY;
        else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = pclip_pkg::S_IN_MUL;
        end
      end
      pclip_pkg::S_CLASSIFY: state_nxt = pclip_pkg::S_ROUTE;
      pclip_pkg::S_ROUTE: begin
        edge_nxt = 1'b0;
        src_nxt  = pclip_pkg::SRC_CUR;
        ret_nxt  = pclip_pkg::S_AFTER;
        if (stat.mid && stat.clip_en) state_nxt = pclip_pkg::S_EDGE;
        else if (!stat.clip_en)       state_nxt = pclip_pkg::S_EMIT;
        else                          state_nxt = pclip_pkg::S_AFTER;
      end
      pclip_pkg::S_AFTER: begin
        if (stat.last && stat.clip_en) begin
          edge_nxt  = 1'b1;
          state_nxt = pclip_pkg::S_EDGE;
        end else begin
          state_nxt = pclip_pkg::S_FINISH;
        end
      end
      pclip_pkg::S_EDGE: begin
        cnt_nxt = '0;
        if (stat.edge_diff) state_nxt = pclip_pkg::S_NUM_MUL;
        else                state_nxt = pclip_pkg::S_EDGE_END;
      end
      pclip_pkg::S_NUM_MUL: state_nxt = pclip_pkg::S_NUM_ACC;
      pclip_pkg::S_NUM_ACC: begin
        if (cnt_r == DOT_LAST) state_nxt = pclip_pkg::S_NUM_SAVE;
        else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = pclip_pkg::S_NUM_MUL;
        end
      end
      pclip_pkg::S_NUM_SAVE: begin
        cnt_nxt   = '0;
        state_nxt = pclip_pkg::S_DEN_MUL;
      end
      pclip_pkg::S_DEN_MUL: state_nxt = pclip_pkg::S_DEN_ACC;
      pclip_pkg::S_DEN_ACC: begin
        if (cnt_r == DOT_LAST) state_nxt = pclip_pkg::S_CHECK;
        else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = pclip_pkg::S_DEN_MUL;
        end
      end
      pclip_pkg::S_CHECK: begin
        if (stat.cross_ok) state_nxt = pclip_pkg::S_DIV_START;
        else               state_nxt = pclip_pkg::S_EDGE_END;
      end
      pclip_pkg::S_DIV_START: begin
        cnt_nxt   = '0;
        state_nxt = pclip_pkg::S_DIV_STEP;
      end
      pclip_pkg::S_DIV_STEP: begin
        if (cnt_r == DIV_LAST) state_nxt = pclip_pkg::S_DIV_DONE;
        else                   cnt_nxt   = cnt_r + 1'b1;
      end
      pclip_pkg::S_DIV_DONE: begin
        cnt_nxt = '0;
        if (stat.q_zero) state_nxt = pclip_pkg::S_EDGE_END;
        else             state_nxt = pclip_pkg::S_INT_MUL;
      end
      pclip_pkg::S_INT_MUL: state_nxt = pclip_pkg::S_INT_ACC;
      pclip_pkg::S_INT_ACC: begin
        if (cnt_r == ATTR_LAST) begin
          src_nxt   = pclip_pkg::SRC_CROSS;
          ret_nxt   = pclip_pkg::S_EDGE_END;
          state_nxt = pclip_pkg::S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = pclip_pkg::S_INT_MUL;
        end
      end
      pclip_pkg::S_EDGE_END: begin
        src_nxt = edge_r ? pclip_pkg::SRC_FIRST : pclip_pkg::SRC_CUR;
        ret_nxt = edge_r ? pclip_pkg::S_FINISH : pclip_pkg::S_AFTER;
        if (stat.e_in)   state_nxt = pclip_pkg::S_EMIT;
        else if (edge_r) state_nxt = pclip_pkg::S_FINISH;
        else             state_nxt = pclip_pkg::S_AFTER;
      end
      pclip_pkg::S_EMIT: begin
        if (!(stat.out_busy && stat.pend_v)) state_nxt = ret_r;
      end
      pclip_pkg::S_FINISH: begin
        if (!(stat.out_busy && (stat.pend_v || stat.last))) state_nxt = pclip_pkg::S_IDLE;
      end
      default: state_nxt = pclip_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.mode     = pclip_pkg::MUL_IN;
    cmd.idx      = cnt_r[pclip_pkg::ATTR_IDX_W-1:0];
    cmd.edge_sel = edge_r;
    cmd.src      = src_r;
    case (state_r)
      pclip_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.cap_in   = stat.in_valid;
        cmd.acc_clr  = stat.in_valid;
      end
      pclip_pkg::S_IN_MUL:   cmd.mul_go = 1'b1;
      pclip_pkg::S_IN_ACC:   cmd.acc_add = 1'b1;
      pclip_pkg::S_CLASSIFY: cmd.set_cur_in = 1'b1;
      pclip_pkg::S_ROUTE:    cmd.set_first = !stat.mid;
      pclip_pkg::S_AFTER:    cmd.upd_prev = 1'b1;
      pclip_pkg::S_EDGE:     cmd.acc_clr = 1'b1;
      pclip_pkg::S_NUM_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.mode   = pclip_pkg::MUL_NUM;
      end
      pclip_pkg::S_NUM_ACC:  cmd.acc_add = 1'b1;
      pclip_pkg::S_NUM_SAVE: begin
        cmd.latch_num = 1'b1;
        cmd.acc_clr   = 1'b1;
      end
      pclip_pkg::S_DEN_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.mode   = pclip_pkg::MUL_DEN;
      end
      pclip_pkg::S_DEN_ACC:   cmd.acc_add = 1'b1;
      pclip_pkg::S_DIV_START: cmd.div_start = 1'b1;
      pclip_pkg::S_DIV_STEP:  cmd.div_step = 1'b1;
      pclip_pkg::S_INT_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.mode   = pclip_pkg::MUL_INT;
      end
      pclip_pkg::S_INT_ACC: cmd.cross_wr = 1'b1;
      pclip_pkg::S_EMIT:    cmd.emit = !(stat.out_busy && stat.pend_v);
      pclip_pkg::S_FINISH:  cmd.finish = !(stat.out_busy && (stat.pend_v || stat.last));
      default: ;
    endcase
  end

endmodule

FILE: hdl/pclip_datapath.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper datapath
// Vertex stores, shared multiplier/accumulator, divider, output staging.
// ----------------------------------------------------------------------------
`include "polygon_plane_clipper_macros.svh"

module pclip_datapath #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  pclip_in_if.sink            in_vtx,
  pclip_out_if.source         out_vtx,
  pclip_cfg_if.sink           cfg_wr,
  input  pclip_pkg::dp_cmd_t  cmd,
  output pclip_pkg::dp_stat_t stat
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 2;       // product width
  localparam int AW = 2 * W + 4 - F;   // dot-product accumulator width
  localparam int TW = F + 1;           // t in [0,1]
  localparam int NA = pclip_pkg::NATTR;

  localparam logic signed [PW-1:0] WMAX = (PW'(1) <<< (W - 1)) - PW'(1);
  localparam logic signed [PW-1:0] WMIN = -WMAX - PW'(1);

  typedef logic signed [W-1:0] word_t;

  function automatic logic signed [W:0] ext(input word_t v);
    ext = {v[W-1], v};
  endfunction

  // configuration
  logic  clip_en_r;
  word_t nrm_r [3];
  word_t pnt_r [3];

  // vertex stores
  word_t in_word [NA];
  word_t cur_r   [NA];
  word_t first_r [NA];
  word_t prev_r  [NA];
  word_t cross_r [NA];
  word_t pend_r  [NA];
  word_t out_r   [NA];
  word_t src_word [NA];

  logic cur_in_r, first_in_r, prev_in_r, mid_r, last_r, pend_v_r;
  logic out_valid_r, out_last_r, out_empty_r, out_load;

  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, num_r;
  logic        [AW:0]   rem_r, rem_shl, ud_ext;
  logic        [AW-1:0] ud_r, un_mag, ud_mag;
  logic        [TW-1:0] q_r;
  logic                 div_ge;

  logic signed [W:0]    mul_a, mul_b;
  logic signed [PW-1:0] prod_sh, cross_sum;
  word_t                s_sel, e_sel, nrm_sel, pnt_sel, cross_sat;
  logic                 s_in, e_in;

  always_comb begin
    in_word[0] = in_vtx.x_coord;
    in_word[1] = in_vtx.y_coord;
    in_word[2] = in_vtx.z_coord;
    in_word[3] = in_vtx.w_coord;
    in_word[4] = in_vtx.red;
    in_word[5] = in_vtx.green;
    in_word[6] = in_vtx.blue;
    in_word[7] = in_vtx.alpha;
    in_word[8] = in_vtx.tex_u;
    in_word[9] = in_vtx.tex_v;
  end

  assign in_vtx.ready = cmd.in_ready;
  assign cfg_wr.ready = 1'b1;

  // edge endpoints: body edge prev->cur, closing edge cur->first
  assign s_sel = cmd.edge_sel ? cur_r[cmd.idx] : prev_r[cmd.idx];
  assign e_sel = cmd.edge_sel ? first_r[cmd.idx] : cur_r[cmd.idx];
  assign s_in  = cmd.edge_sel ? cur_in_r : prev_in_r;
  assign e_in  = cmd.edge_sel ? first_in_r : cur_in_r;

  always_comb begin
    case (cmd.idx[1:0])
      2'd0:    begin nrm_sel = nrm_r[0]; pnt_sel = pnt_r[0]; end
      2'd1:    begin nrm_sel = nrm_r[1]; pnt_sel = pnt_r[1]; end
      default: begin nrm_sel = nrm_r[2]; pnt_sel = pnt_r[2]; end
    endcase
  end

  always_comb begin
    mul_a = ext(nrm_sel);
    case (cmd.mode)
      pclip_pkg::MUL_IN:  mul_b = ext(cur_r[cmd.idx]) - ext(pnt_sel);
      pclip_pkg::MUL_NUM: mul_b = ext(pnt_sel) - ext(s_sel);
      pclip_pkg::MUL_DEN: mul_b = ext(e_sel) - ext(s_sel);
      default: begin
        mul_a = ext(e_sel) - ext(s_sel);
        mul_b = (W + 1)'(q_r);
      end
    endcase
  end

  // floor shift of the exact product
  assign prod_sh   = prod_r >>> F;
  assign cross_sum = PW'(s_sel) + prod_sh;
  assign cross_sat = (cross_sum > WMAX) ? W'(WMAX) :
                     (cross_sum < WMIN) ? W'(WMIN) : W'(cross_sum);

  // crossing checks: acc holds the denominator here
  assign un_mag  = num_r[AW-1] ? AW'(-num_r) : AW'(num_r);
  assign ud_mag  = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign rem_shl = {rem_r[AW-1:0], 1'b0};
  assign ud_ext  = {1'b0, ud_r};
  assign div_ge  = rem_shl >= ud_ext;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      case (cmd.src)
        pclip_pkg::SRC_FIRST: src_word[i] = first_r[i];
        pclip_pkg::SRC_CROSS: src_word[i] = cross_r[i];
        default:              src_word[i] = cur_r[i];
      endcase
    end
  end

  assign out_load = (cmd.emit && pend_v_r) || (cmd.finish && (pend_v_r || last_r));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_en_r <= 1'b1;
      nrm_r[0]  <= -(word_t'(1) <<< F);
      nrm_r[1]  <= '0;
      nrm_r[2]  <= '0;
      pnt_r[0]  <= word_t'(pclip_pkg::PNT_X_RST);
      pnt_r[1]  <= '0;
      pnt_r[2]  <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        pclip_pkg::REG_CLIP_EN: clip_en_r <= cfg_wr.data[0];
        pclip_pkg::REG_NRM_X:   nrm_r[0]  <= cfg_wr.data;
        pclip_pkg::REG_NRM_Y:   nrm_r[1]  <= cfg_wr.data;
        pclip_pkg::REG_NRM_Z:   nrm_r[2]  <= cfg_wr.data;
        pclip_pkg::REG_PNT_X:   pnt_r[0]  <= cfg_wr.data;
        pclip_pkg::REG_PNT_Y:   pnt_r[1]  <= cfg_wr.data;
        pclip_pkg::REG_PNT_Z:   pnt_r[2]  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_in_r    <= 1'b0;
      first_in_r  <= 1'b0;
      prev_in_r   <= 1'b0;
      mid_r       <= 1'b0;
      last_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cap_in)     last_r   <= in_vtx.last_vertex;
      if (cmd.set_cur_in) cur_in_r <= !acc_r[AW-1];
      if (cmd.set_first) begin
        first_in_r <= cur_in_r;
        mid_r      <= 1'b1;
      end
      if (cmd.upd_prev) prev_in_r <= cur_in_r;
      if (cmd.emit)     pend_v_r  <= 1'b1;
      if (cmd.finish) begin
        pend_v_r <= 1'b0;
        if (last_r) mid_r <= 1'b0;
      end
      if (out_load)           out_valid_r <= 1'b1;
      else if (out_vtx.ready) out_valid_r <= 1'b0;
    end
  end

  // arithmetic and payload
  always_ff @(posedge clk) begin
    if (cmd.mul_go) prod_r <= PW'(mul_a) * PW'(mul_b);
    if (cmd.acc_clr)      acc_r <= '0;
    else if (cmd.acc_add) acc_r <= acc_r + AW'(prod_sh);
    if (cmd.latch_num) num_r <= acc_r;
    if (cmd.div_start) begin
      ud_r <= ud_mag;
      if (un_mag == ud_mag) begin
        q_r   <= TW'(1);
        rem_r <= '0;
      end else begin
        q_r   <= '0;
        rem_r <= {1'b0, un_mag};
      end
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? (rem_shl - ud_ext) : rem_shl;
      q_r   <= {q_r[TW-2:0], div_ge};
    end
    if (cmd.cross_wr) cross_r[cmd.idx] <= cross_sat;
    for (int i = 0; i < NA; i++) begin
      if (cmd.cap_in)    cur_r[i]   <= in_word[i];
      if (cmd.set_first) first_r[i] <= cur_r[i];
      if (cmd.upd_prev)  prev_r[i]  <= cur_r[i];
      if (cmd.emit)      pend_r[i]  <= src_word[i];
      if (out_load)      out_r[i]   <= pend_v_r ? pend_r[i] : '0;
    end
    if (out_load) begin
      out_last_r  <= cmd.finish && last_r;
      out_empty_r <= !pend_v_r;
    end
  end

  assign out_vtx.valid         = out_valid_r;
  assign out_vtx.x_out         = out_r[0];
  assign out_vtx.y_out         = out_r[1];
  assign out_vtx.z_out         = out_r[2];
  assign out_vtx.w_out         = out_r[3];
  assign out_vtx.red_out       = out_r[4];
  assign out_vtx.green_out     = out_r[5];
  assign out_vtx.blue_out      = out_r[6];
  assign out_vtx.alpha_out     = out_r[7];
  assign out_vtx.tex_u_out     = out_r[8];
  assign out_vtx.tex_v_out     = out_r[9];
  assign out_vtx.last_out      = out_last_r;
  assign out_vtx.empty_polygon = out_empty_r;

  always_comb begin
    stat.in_valid  = in_vtx.valid;
    stat.mid       = mid_r;
    stat.clip_en   = clip_en_r;
    stat.last      = last_r;
    stat.edge_diff = s_in != e_in;
    stat.e_in      = e_in;
    stat.cross_ok  = (acc_r != '0) && (num_r != '0) &&
                     (num_r[AW-1] == acc_r[AW-1]) && (un_mag <= ud_mag);
    stat.q_zero    = q_r == '0;
    stat.pend_v    = pend_v_r;
    stat.out_busy  = out_valid_r && !out_vtx.ready;
  end

  // output register is never overwritten while a result is stalled
  `PCLIP_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_r || out_vtx.ready)
  // divider remainder stays below the divisor
  `PCLIP_ASSERT_IMP(a_div_rem, cmd.div_step, rem_r < ud_ext)
  // interpolation only runs with a nonzero t
  `PCLIP_ASSERT_IMP(a_cross_t, cmd.cross_wr, q_r != '0)
  // an input is only taken with no result held back
  `PCLIP_ASSERT_NXT(a_cap_clean, cmd.cap_in, !pend_v_r)

endmodule

FILE: hdl/polygon_plane_clipper.sv
// Flow: an input vertex is classified with a three-term dot; each crossing
//   adds numerator and denominator dots, a start step and FRAC_BITS divider
//   steps, and ten interpolations; a closing vertex can have two crossings.
// The block takes one vertex at a time; output stalls can hold it up.
// ----------------------------------------------------------------------------
// Polygon plane clipper
// Streamed single-plane polygon clipper with attribute interpolation.
// Reset: synchronous active-low rst_n; control and configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module polygon_plane_clipper #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pclip_in_if.sink    in_vtx,
  pclip_out_if.source out_vtx,
  pclip_cfg_if.sink   cfg_wr
);

  // Controller walks each vertex: classify it against the plane (three
  // multiply-accumulates), then for the body edge and, on the last vertex,
  // the closing edge: numerator and denominator dots, a restoring divide
  // for t, and interpolation of all ten attributes on the one multiplier.
  // Results go through a one-deep hold stage so the final one of a polygon
  // can be flagged last before it reaches the output register; a stalled output
  // transfer holds up the controller once the hold stage also has to unload.
  pclip_pkg::dp_cmd_t  cmd;
  pclip_pkg::dp_stat_t stat;

  pclip_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  pclip_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (in_vtx),
    .out_vtx (out_vtx),
    .cfg_wr  (cfg_wr),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

FILE: tb/polygon_plane_clipper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon plane clipper testbench
// Streams polygons through the clipper under several plane settings and
// checks every output vertex against a fixed-point clipping predictor.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [31:0] attr[10];
  bit                 last;
  bit                 empty;
} clip_vtx_t;

// Predicts the clipped vertex stream and checks the block's output against it.
class clip_scoreboard;
  localparam longint unsigned SAT_LIM = 64'd1 << 61;

  bit        clip_en;
  longint    nrm[3];
  longint    pnt[3];
  longint    first_v[10];
  longint    prev_v[10];
  bit        first_in, prev_in, mid_poly;
  clip_vtx_t expected_vtx[$];
  int        errors;

  function void reset();
    clip_en = 1;
    nrm = '{-65536, 0, 0};
    pnt = '{pclip_pkg::PNT_X_RST, 0, 0};
    first_in = 0; prev_in = 0; mid_poly = 0;
    expected_vtx.delete();
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      pclip_pkg::REG_CLIP_EN: clip_en = data[0];
      pclip_pkg::REG_NRM_X:   nrm[0] = longint'(signed'(data));
      pclip_pkg::REG_NRM_Y:   nrm[1] = longint'(signed'(data));
      pclip_pkg::REG_NRM_Z:   nrm[2] = longint'(signed'(data));
      pclip_pkg::REG_PNT_X:   pnt[0] = longint'(signed'(data));
      pclip_pkg::REG_PNT_Y:   pnt[1] = longint'(signed'(data));
      pclip_pkg::REG_PNT_Z:   pnt[2] = longint'(signed'(data));
      default: ;
    endcase
  endfunction

  // exact product, floor shift by the fraction width, clamp to +-2^61
  function longint fx_mul(longint a, longint b);
    bit                 neg;
    logic [127:0]       prod, q;
    longint unsigned    ua, ub;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    q = prod >> 16;
    if (neg && prod[15:0] != 0) q++;
    if (q > SAT_LIM) q = SAT_LIM;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function longint plane_dot(longint dx, longint dy, longint dz);
    return fx_mul(nrm[0], dx) + fx_mul(nrm[1], dy) + fx_mul(nrm[2], dz);
  endfunction

  function bit side_in(longint v[10]);
    return plane_dot(v[0] - pnt[0], v[1] - pnt[1], v[2] - pnt[2]) >= 0;
  endfunction

  function longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void add_vtx(ref clip_vtx_t res[$], input longint v[10], input bit empty);
    clip_vtx_t r;
    for (int i = 0; i < 10; i++) r.attr[i] = empty ? 32'sd0 : v[i][31:0];
    r.last = 0;
    r.empty = empty;
    res.push_back(r);
  endfunction

  // one edge s->e: crossing (if any) then the end vertex when inside
  function void clip_edge(ref clip_vtx_t res[$], input longint s[10], input bit s_in,
                          input longint e[10], input bit e_in);
    longint          num, den, c[10];
    longint unsigned un, ud;
    logic [127:0]    t;
    if (s_in != e_in) begin
      num = plane_dot(pnt[0] - s[0], pnt[1] - s[1], pnt[2] - s[2]);
      den = plane_dot(e[0] - s[0], e[1] - s[1], e[2] - s[2]);
      if (den != 0 && num != 0 && ((num > 0) == (den > 0))) begin
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        if (un <= ud) begin
          t = ({64'd0, un} << 16) / {64'd0, ud};
          if (t != 0) begin
            for (int i = 0; i < 10; i++)
              c[i] = sat32(s[i] + fx_mul(e[i] - s[i], longint'(t[63:0])));
            add_vtx(res, c, 0);
          end
        end
      end
    end
    if (e_in) add_vtx(res, e, 0);
  endfunction

  function void note_vertex(logic signed [31:0] a[10], bit last);
    longint    v[10];
    bit        cur_in;
    clip_vtx_t res[$];
    for (int i = 0; i < 10; i++) v[i] = a[i];
    cur_in = side_in(v);
    if (!mid_poly) begin
      first_v = v;
      first_in = cur_in;
      mid_poly = 1;
      if (!clip_en) add_vtx(res, v, 0);
    end else if (clip_en) begin
      clip_edge(res, prev_v, prev_in, v, cur_in);
    end else begin
      add_vtx(res, v, 0);
    end
    prev_v = v;
    prev_in = cur_in;
    if (last && clip_en) clip_edge(res, v, cur_in, first_v, first_in);
    if (last) begin
      if (res.size() == 0) add_vtx(res, v, 1);
      res[res.size() - 1].last = 1;
      mid_poly = 0;
    end
    foreach (res[i]) expected_vtx.push_back(res[i]);
  endfunction

  function void check_vtx(clip_vtx_t got);
    string     names[10] = '{"x_out", "y_out", "z_out", "w_out", "red_out", "green_out",
                             "blue_out", "alpha_out", "tex_u_out", "tex_v_out"};
    clip_vtx_t exp_v;
    if (expected_vtx.size() == 0) begin
      $error("unexpected output vertex x_out=%0d", got.attr[0]);
      errors++;
      return;
    end
    exp_v = expected_vtx.pop_front();
    for (int i = 0; i < 10; i++)
      if (got.attr[i] !== exp_v.attr[i]) begin
        $error("%s: expected %0d, got %0d", names[i], exp_v.attr[i], got.attr[i]);
        errors++;
      end
    if (got.last !== exp_v.last) begin
      $error("last_out: expected %0d, got %0d", exp_v.last, got.last);
      errors++;
    end
    if (got.empty !== exp_v.empty) begin
      $error("empty_polygon: expected %0d, got %0d", exp_v.empty, got.empty);
      errors++;
    end
  endfunction
endclass

module polygon_plane_clipper_tb;

  localparam int CYCLE_LIMIT = 900000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [2:0] REG_UNUSED = 3'd7;  // no register at this index

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pclip_in_if  #(.WORD_BITS(32)) in_if ();
  pclip_out_if #(.WORD_BITS(32)) out_if ();
  pclip_cfg_if #(.WORD_BITS(32)) cfg_if ();

  polygon_plane_clipper #(.WORD_BITS(32), .FRAC_BITS(16)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (in_if),
    .out_vtx (out_if),
    .cfg_wr  (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  clip_scoreboard sb = new();
  bit quiet_mode = 0;  // no idling on either side near the end
  int cycle_cnt = 0;
  int stall_left = 0;

  // all inputs known from time zero
  initial begin
    in_if.valid = 1'b0;
    in_if.last_vertex = 1'b0;
    {in_if.x_coord, in_if.y_coord, in_if.z_coord, in_if.w_coord, in_if.red,
     in_if.green, in_if.blue, in_if.alpha, in_if.tex_u, in_if.tex_v} = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  // result side backpressure: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitors: every transfer sampled at the edge it happens on
  always @(posedge clk) begin
    clip_vtx_t got;
    logic signed [31:0] vin[10];
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (out_if.valid && out_if.ready) begin
        got.attr = '{out_if.x_out, out_if.y_out, out_if.z_out, out_if.w_out,
                     out_if.red_out, out_if.green_out, out_if.blue_out,
                     out_if.alpha_out, out_if.tex_u_out, out_if.tex_v_out};
        got.last = out_if.last_out;
        got.empty = out_if.empty_polygon;
        sb.check_vtx(got);
      end
      if (in_if.valid && in_if.ready) begin
        vin = '{in_if.x_coord, in_if.y_coord, in_if.z_coord, in_if.w_coord,
                in_if.red, in_if.green, in_if.blue, in_if.alpha, in_if.tex_u,
                in_if.tex_v};
        sb.note_vertex(vin, in_if.last_vertex);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one vertex transfer, optionally after a short sender gap
  task automatic send_vertex(logic signed [31:0] a[10], bit last);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    {in_if.x_coord, in_if.y_coord, in_if.z_coord, in_if.w_coord, in_if.red,
     in_if.green, in_if.blue, in_if.alpha, in_if.tex_u, in_if.tex_v} <=
      {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8], a[9]};
    in_if.last_vertex <= last;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // drop valid, let the monitor note the final transfer, let all expected
  // vertices arrive, then let the block settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_vtx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_plane(logic [31:0] nx, ny, nz, px, py, pz, bit en);
    write_reg(pclip_pkg::REG_CLIP_EN, {31'd0, en});
    write_reg(pclip_pkg::REG_NRM_X, nx);
    write_reg(pclip_pkg::REG_NRM_Y, ny);
    write_reg(pclip_pkg::REG_NRM_Z, nz);
    write_reg(pclip_pkg::REG_PNT_X, px);
    write_reg(pclip_pkg::REG_PNT_Y, py);
    write_reg(pclip_pkg::REG_PNT_Z, pz);
  endtask

  function automatic logic [31:0] rnd_near(int range);
    return 32'($signed($urandom_range(0, 2 * range)) - range);
  endfunction

  // vertex with given position; other attributes random over full range
  function automatic void mk_vtx(output logic signed [31:0] a[10],
                                 input logic [31:0] x, y, z);
    a[0] = x; a[1] = y; a[2] = z;
    for (int i = 3; i < 10; i++) a[i] = $urandom;
  endfunction

  // random polygon: mostly positions near the plane, sometimes full range
  task automatic send_polygon(int nvert, int range);
    logic signed [31:0] a[10];
    for (int k = 0; k < nvert; k++) begin
      if ($urandom_range(0, 9) == 0) mk_vtx(a, $urandom, $urandom, $urandom);
      else mk_vtx(a, rnd_near(range), rnd_near(range), rnd_near(range));
      send_vertex(a, k == nvert - 1);
    end
  endtask

  initial begin
    logic signed [31:0] a[10];
    int range;
    sb.reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset plane: inside is x <= ~0.1 ---
    // triangle crossing the plane twice (one entry, one exit)
    mk_vtx(a, -32'sd65536, 0, 0);         send_vertex(a, 0);
    mk_vtx(a, 32'sd131072, 32'sd65536, 0); send_vertex(a, 0);
    mk_vtx(a, -32'sd65536, 32'sd131072, 0); send_vertex(a, 1);
    // single vertex polygons, inside then outside
    mk_vtx(a, 0, 0, 0);                   send_vertex(a, 1);
    mk_vtx(a, 32'sd655360, 0, 0);         send_vertex(a, 1);
    // fully clipped polygon
    mk_vtx(a, 32'sd196608, 0, 0);         send_vertex(a, 0);
    mk_vtx(a, 32'sd262144, 32'sd65536, 0); send_vertex(a, 1);
    // edge lying in the plane (two vertices on it), then a vertex just outside
    mk_vtx(a, 32'sd6553, 0, 0);           send_vertex(a, 0);
    mk_vtx(a, 32'sd6553, 32'sd65536, 0);  send_vertex(a, 0);
    mk_vtx(a, 32'sd6554, 0, 0);           send_vertex(a, 1);
    // field extremes
    for (int i = 0; i < 10; i++) a[i] = 32'h7fffffff;
    send_vertex(a, 0);
    for (int i = 0; i < 10; i++) a[i] = 32'h80000000;
    send_vertex(a, 0);
    for (int i = 0; i < 10; i++) a[i] = 32'h0;
    send_vertex(a, 1);
    wait_idle();

    // extreme plane, unreachable index, and enable toggled mid-polygon
    set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h0, 1);
    write_reg(REG_UNUSED, $urandom);
    send_polygon(4, 32'sd2147483647);
    mk_vtx(a, 32'h80000000, 0, 32'h7fffffff); send_vertex(a, 0);
    mk_vtx(a, 32'h7fffffff, 32'h80000000, 0); send_vertex(a, 0);
    wait_idle();
    write_reg(pclip_pkg::REG_CLIP_EN, 32'd0);
    mk_vtx(a, $urandom, $urandom, $urandom); send_vertex(a, 0);
    wait_idle();
    write_reg(pclip_pkg::REG_CLIP_EN, 32'd1);
    mk_vtx(a, $urandom, $urandom, $urandom); send_vertex(a, 1);
    wait_idle();

    // --- random phases: new plane each phase, last ones without idling ---
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 7) quiet_mode = 1;
      case (ph % 4)
        0: set_plane(rnd_near(131072), rnd_near(131072), rnd_near(131072),
                     rnd_near(131072), rnd_near(131072), rnd_near(131072), 1);
        1: set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
        2: set_plane(32'hffff0000, 32'h0, 32'h0, 32'd6553, 32'h0, 32'h0,
                     $urandom_range(0, 3) == 0 ? 1'b0 : 1'b1);
        default: set_plane(rnd_near(65536), rnd_near(65536), 32'h0,
                           32'h0, 32'h0, rnd_near(65536), 1);
      endcase
      range = (ph % 4 == 1) ? 32'sd2147483647 : 32'sd524288;
      for (int n = 0; n < 40; ) begin
        int nv;
        nv = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
        send_polygon(nv, range);
        n += nv;
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
